// ----- sv/csp12f_pkg.sv -----
`timescale 1ns / 1ps
// Package for the C source phase 1/2 filter: payload structs, character
// constants, the trigraph map and the result bundle passed front to back.
// No dependencies.
package csp12f_pkg;

  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_QMARK  = 8'h3F;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;

  // Most result bytes one request can release.
  localparam int unsigned MaxRes = 4;
  localparam int unsigned ResIdxW = $clog2(MaxRes);
  // Depth of the bundle queue between front and back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_t;

  // All results caused by one input request.
  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [ResIdxW-1:0]     cnt_m1;  // number of results minus one
    logic                   mark;    // single empty end marker
    logic                   last;    // final result carries out_last
  } bundle_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] rep;
  } trig_t;

  function automatic trig_t trigraph_map(logic [7:0] c);
    trig_t t;
    t.hit = 1'b1;
    case (c)
      8'h3D:   t.rep = 8'h23;  // = -> #
      8'h2F:   t.rep = 8'h5C;  // / -> backslash
      8'h27:   t.rep = 8'h5E;  // ' -> ^
      8'h28:   t.rep = 8'h5B;  // ( -> [
      8'h29:   t.rep = 8'h5D;  // ) -> ]
      8'h21:   t.rep = 8'h7C;  // ! -> |
      8'h3C:   t.rep = 8'h7B;  // < -> {
      8'h3E:   t.rep = 8'h7D;  // > -> }
      8'h2D:   t.rep = 8'h7E;  // - -> ~
      default: begin
        t.hit = 1'b0;
        t.rep = 8'h00;
      end
    endcase
    return t;
  endfunction

endpackage

// ----- sv/csp12f_front.sv -----
`timescale 1ns / 1ps
// Front end: CR/LF folding, trigraph replacement and line splicing state.
// Turns one accepted input request into a bundle of up to four results.
// Depends on csp12f_pkg.
module csp12f_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  csp12f_pkg::in_t    in_data_i,
  output logic               push_o,
  output csp12f_pkg::bundle_t bundle_o
);

  logic       skip_q, skip_d;
  logic [1:0] qcnt_q, qcnt_d;
  logic       hb_q, hb_d;

  logic [7:0]  cin;
  logic [7:0]  tc;
  logic        do_trig;
  csp12f_pkg::trig_t trig;
  logic [7:0]  pch [4];
  logic [1:0]  np;
  logic        hb;
  logic [2:0]  cnt;
  logic [7:0]  ob [4];

  always_comb begin
    cin     = in_data_i.in_byte;
    skip_d  = 1'b0;
    qcnt_d  = qcnt_q;
    do_trig = 1'b1;
    tc      = cin;
    np      = 2'd0;
    for (int i = 0; i < 4; i++) begin
      pch[i] = 8'h00;
      ob[i]  = 8'h00;
    end

    // Phase 1: CR to LF, drop LF of a CR LF pair.
    if (cin == csp12f_pkg::CHR_CR) begin
      skip_d = 1'b1;
      tc     = csp12f_pkg::CHR_LF;
    end else if (cin == csp12f_pkg::CHR_LF && skip_q) begin
      do_trig = 1'b0;
    end

    trig = csp12f_pkg::trigraph_map(tc);

    // Trigraphs: build the list of bytes for the splice stage.
    if (do_trig) begin
      if (tc == csp12f_pkg::CHR_QMARK) begin
        if (qcnt_q < 2'd2) begin
          qcnt_d = qcnt_q + 2'd1;
        end else begin
          pch[0] = csp12f_pkg::CHR_QMARK;
          np     = 2'd1;
        end
      end else if (qcnt_q == 2'd2 && trig.hit) begin
        qcnt_d = 2'd0;
        pch[0] = trig.rep;
        np     = 2'd1;
      end else begin
        qcnt_d = 2'd0;
        case (qcnt_q)
          2'd0: begin
            pch[0] = tc;
            np     = 2'd1;
          end
          2'd1: begin
            pch[0] = csp12f_pkg::CHR_QMARK;
            pch[1] = tc;
            np     = 2'd2;
          end
          default: begin
            pch[0] = csp12f_pkg::CHR_QMARK;
            pch[1] = csp12f_pkg::CHR_QMARK;
            pch[2] = tc;
            np     = 2'd3;
          end
        endcase
      end
    end

    // End of file releases held question marks.
    if (in_data_i.in_last) begin
      for (int i = 0; i < 2; i++) begin
        if (i < int'(qcnt_d)) begin
          pch[np] = csp12f_pkg::CHR_QMARK;
          np      = np + 2'd1;
        end
      end
      qcnt_d = 2'd0;
    end

    // Phase 2: backslash-newline removal.
    hb  = hb_q;
    cnt = 3'd0;
    for (int i = 0; i < 3; i++) begin
      if (i < int'(np)) begin
        if (hb && pch[i] == csp12f_pkg::CHR_LF) begin
          hb = 1'b0;
        end else begin
          if (hb) begin
            ob[cnt[1:0]] = csp12f_pkg::CHR_BSLASH;
            cnt          = cnt + 3'd1;
            hb           = 1'b0;
          end
          if (pch[i] == csp12f_pkg::CHR_BSLASH) begin
            hb = 1'b1;
          end else begin
            ob[cnt[1:0]] = pch[i];
            cnt          = cnt + 3'd1;
          end
        end
      end
    end

    bundle_o.mark = 1'b0;
    if (in_data_i.in_last) begin
      if (hb) begin
        ob[cnt[1:0]] = csp12f_pkg::CHR_BSLASH;
        cnt          = cnt + 3'd1;
      end
      hb     = 1'b0;
      skip_d = 1'b0;
      if (cnt == 3'd0) begin
        bundle_o.mark = 1'b1;
        cnt           = 3'd1;
      end
    end
    hb_d = hb;

    for (int i = 0; i < 4; i++) begin
      bundle_o.bytes[i] = ob[i];
    end
    bundle_o.cnt_m1 = 2'(cnt - 3'd1);
    bundle_o.last   = in_data_i.in_last;
    push_o          = accept_i && (cnt != 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= 1'b0;
      qcnt_q <= 2'd0;
      hb_q   <= 1'b0;
    end else if (accept_i) begin
      skip_q <= skip_d;
      qcnt_q <= qcnt_d;
      hb_q   <= hb_d;
    end
  end

endmodule

// ----- sv/csp12f_queue.sv -----
`timescale 1ns / 1ps
// Short bundle queue between the front end and the output sequencer.
// Depends on csp12f_pkg.
module csp12f_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  csp12f_pkg::bundle_t wdata_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                nonempty_o,
  output csp12f_pkg::bundle_t rdata_o
);

  csp12f_pkg::bundle_t mem_q [csp12f_pkg::QDepth];
  logic [csp12f_pkg::QPtrW-1:0] wptr_q, rptr_q;
  logic [csp12f_pkg::QCntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == csp12f_pkg::QCntW'(csp12f_pkg::QDepth));
  assign nonempty_o = (cnt_q != '0);
  assign rdata_o    = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- sv/csp12f_back.sv -----
`timescale 1ns / 1ps
// Back end: walks the head bundle one result per cycle, while the receiver takes them, into the output register.
// Depends on csp12f_pkg.
module csp12f_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  csp12f_pkg::bundle_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output csp12f_pkg::out_t    out_data_o
);

  logic [csp12f_pkg::ResIdxW-1:0] idx_q, idx_d;
  logic                           ovld_q, ovld_d;
  csp12f_pkg::out_t               out_q, out_d;
  logic                           load;
  logic                           at_end;

  always_comb begin
    load   = head_valid_i && (!ovld_q || out_ready_i);
    at_end = (idx_q == head_i.cnt_m1);
    pop_o  = load && at_end;
    idx_d  = idx_q;
    ovld_d = ovld_q;
    out_d  = out_q;
    if (ovld_q && out_ready_i) begin
      ovld_d = 1'b0;
    end
    if (load) begin
      ovld_d          = 1'b1;
      out_d.out_byte  = head_i.bytes[idx_q];
      out_d.out_valid = !head_i.mark;
      out_d.out_last  = head_i.last && at_end;
      idx_d           = at_end ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/c_source_phase12_filter.sv -----
`timescale 1ns / 1ps
// C source translation phases 1 and 2 as a byte stream filter (top level).
// Depends on csp12f_pkg, csp12f_front, csp12f_queue and csp12f_back.
//
// Input channel: in_valid_i / in_ready_o with in_data_i = {in_byte, in_last}.
// One raw source byte per request; in_last on the final byte of a file
// flushes held '?' and backslash bytes and resets the filter state.
// Output channel: out_valid_o / out_ready_i with out_data_o = {out_byte,
// out_valid, out_last}. A file ends with one result that has out_last set;
// it may be an empty marker (out_valid = 0, out_byte = 0).
// The first result of a request passes the bundle queue and then the output
// register before it is offered. Throughput: one result per cycle at the
// output while the receiver is ready, one request per cycle at the input
// while each request yields at most one result; a request with up to four
// results holds the output sequencer; the two-entry queue absorbs the excess.
// When the receiver stalls, the output register holds, the queue fills and
// in_ready_o falls once both entries are taken. Reset clears the filter
// state, the queue and the output register valid; no clearing pass.
module c_source_phase12_filter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  csp12f_pkg::in_t      in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output csp12f_pkg::out_t     out_data_o
);

  logic                q_full;
  logic                q_nonempty;
  logic                accept;
  logic                push;
  logic                pop;
  csp12f_pkg::bundle_t wbundle;
  csp12f_pkg::bundle_t head;

  // Ready depends only on queue occupancy, never on the output side.
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  csp12f_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push),
    .bundle_o  (wbundle)
  );

  csp12f_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .wdata_i    (wbundle),
    .pop_i      (pop),
    .full_o     (q_full),
    .nonempty_o (q_nonempty),
    .rdata_o    (head)
  );

  csp12f_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_nonempty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
